// ===== design/sct_pkg.sv =====
// Shared types and codes for the sorted card table.
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;

	localparam int KEY_W = 8;
	localparam int PAY_W = 3;
	localparam int POS_W = 7;
	localparam int CNT_OUT_W = 8;

	localparam logic [1:0] OP_INS_FRONT  = 2'd0;
	localparam logic [1:0] OP_INS_SORTED = 2'd1;
	localparam logic [1:0] OP_READ       = 2'd2;
	localparam logic [1:0] OP_REMOVE     = 2'd3;

	typedef struct packed {
		logic [1:0]       operation;
		logic [KEY_W-1:0] card_key;
		logic [PAY_W-1:0] card_payload;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [KEY_W-1:0]     out_key;
		logic [PAY_W-1:0]     out_payload;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

	// Operation broadcast to every cell while a wave is in flight.
	typedef struct packed {
		logic             ins;
		logic             rd;
		logic             rm;
		logic             en;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// Token that walks the chain one cell per cycle.
	typedef struct packed {
		logic             vld;
		logic             placed;
		logic [KEY_W-1:0] carry_key;
		logic [PAY_W-1:0] carry_pay;
		logic [KEY_W-1:0] res_key;
		logic [PAY_W-1:0] res_pay;
	} wave_t;

endpackage
`default_nettype wire

// ===== design/sct_cell.sv =====
// One table slot: holds an entry and acts on the wave as it passes.
`timescale 1ns / 1ps
`default_nettype none
module sct_cell
	import sct_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CMP_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [CMP_W-1:0] pos,
	input  wire logic [CMP_W-1:0] cnt,
	input  wire wave_t            wave_in,
	output wave_t                 wave_out,
	input  wire logic [KEY_W-1:0] right_key,
	input  wire logic [PAY_W-1:0] right_pay,
	output logic [KEY_W-1:0]      own_key,
	output logic [PAY_W-1:0]      own_pay
);

	localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] NEXT_C = CMP_W'(IDX + 1);
	localparam bit FIRST = (IDX == 0);

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	wave_t            wave_q;
	wave_t            wave_nxt;
	logic             act;
	logic             hit;
	logic             store;
	logic             take_right;

	assign act = wave_in.vld & cmd.en;
	// slot 0 hits only on a strictly greater key, the other slots also on an equal one
	assign hit = FIRST ? (key_q > cmd.key) : (key_q >= cmd.key);

	always_comb begin
		wave_nxt   = wave_in;
		store      = 1'b0;
		take_right = 1'b0;
		if (act) begin
			if (cmd.ins) begin
				if (IDX_C < cnt) begin
					if (wave_in.placed || hit) begin
						store              = 1'b1;
						wave_nxt.carry_key = key_q;
						wave_nxt.carry_pay = pay_q;
						wave_nxt.placed    = 1'b1;
					end
				end else if (IDX_C == cnt) begin
					store           = 1'b1;
					wave_nxt.placed = 1'b1;
				end
			end
			if ((cmd.rd || cmd.rm) && IDX_C == pos) begin
				wave_nxt.res_key = key_q;
				wave_nxt.res_pay = pay_q;
			end
			if (cmd.rm && IDX_C >= pos && NEXT_C < cnt) begin
				take_right = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			key_q <= wave_in.carry_key;
			pay_q <= wave_in.carry_pay;
		end else if (take_right) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_nxt;
		end
	end

	assign wave_out = wave_q;
	assign own_key  = key_q;
	assign own_pay  = pay_q;

endmodule
`default_nettype wire

// ===== design/sct_ctrl.sv =====
// Request decode, entry counter, wave launch and response buffering.
`timescale 1ns / 1ps
`default_nettype none
module sct_ctrl
	import sct_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp,
	output cmd_t      cmd,
	output logic [((($clog2(CAPACITY + 1)) > POS_W) ? $clog2(CAPACITY + 1) : POS_W)-1:0] pos,
	output logic [((($clog2(CAPACITY + 1)) > POS_W) ? $clog2(CAPACITY + 1) : POS_W)-1:0] cnt,
	output wave_t     launch,
	input  wire wave_t tail
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] count_q;
	cmd_t             cmd_q;
	logic [CMP_W-1:0] pos_q;
	logic [CMP_W-1:0] cnt_q;
	wave_t            launch_q;
	rsp_t             rsp_q;
	rsp_t             hold_q;
	logic             rsp_vld_q;

	logic             accept;
	logic             is_ins;
	logic             is_rd;
	logic             is_rm;
	logic             ok;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [EXT_W-1:0] cnt_wide;
	logic             out_free;
	logic             load_tail;
	logic             load_hold;
	logic             to_hold;
	rsp_t             tail_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;

	assign is_ins  = (req.operation == OP_INS_FRONT) || (req.operation == OP_INS_SORTED);
	assign is_rd   = (req.operation == OP_READ);
	assign is_rm   = (req.operation == OP_REMOVE);
	assign cnt_ext = CMP_W'(count_q);
	assign pos_ext = CMP_W'(req.position);
	assign ok      = is_ins ? (cnt_ext < CAP_C) : (pos_ext < cnt_ext);

	assign cnt_wide = EXT_W'(count_q);
	always_comb begin
		tail_rsp             = '0;
		tail_rsp.ok          = cmd_q.en;
		tail_rsp.out_key     = tail.res_key;
		tail_rsp.out_payload = tail.res_pay;
		tail_rsp.entry_count = cnt_wide[CNT_OUT_W-1:0];
	end

	assign out_free = !rsp_vld_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		load_tail = 1'b0;
		load_hold = 1'b0;
		to_hold   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (tail.vld) begin
					if (out_free) begin
						load_tail = 1'b1;
						state_nxt = S_IDLE;
					end else begin
						to_hold   = 1'b1;
						state_nxt = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (out_free) begin
					load_hold = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			launch_q  <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q      <= state_nxt;
			launch_q.vld <= accept;
			if (accept) begin
				launch_q.placed    <= (req.operation == OP_INS_FRONT);
				launch_q.carry_key <= req.card_key;
				launch_q.carry_pay <= req.card_payload;
				launch_q.res_key   <= '0;
				launch_q.res_pay   <= '0;
			end
			if (accept && ok) begin
				if (is_ins) begin
					count_q <= count_q + CNT_W'(1);
				end else if (is_rm) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (load_tail || load_hold) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.ins <= is_ins;
			cmd_q.rd  <= is_rd;
			cmd_q.rm  <= is_rm;
			cmd_q.en  <= ok;
			cmd_q.key <= req.card_key;
			pos_q     <= pos_ext;
			cnt_q     <= cnt_ext;
		end
		if (to_hold) begin
			hold_q <= tail_rsp;
		end
		if (load_tail) begin
			rsp_q <= tail_rsp;
		end else if (load_hold) begin
			rsp_q <= hold_q;
		end
	end

	assign cmd       = cmd_q;
	assign pos       = pos_q;
	assign cnt       = cnt_q;
	assign launch    = launch_q;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_vld_q;

endmodule
`default_nettype wire

// ===== design/sorted_card_table.sv =====
// Sorted card table: bounded ordered table built as a chain of entry cells.
//
// Requests arrive on req_valid/req_ready with a req_t payload: insert at
// front, sorted insert, read by position or remove by position. Each
// transaction returns exactly one rsp_t on rsp_valid/rsp_ready holding the
// ok flag, the entry read or removed (zero otherwise) and the entry count.
// Every operation sends a wave through all CAPACITY cells, one cell per
// cycle; each cell shifts, stores or reports its entry as the wave passes.
// The request is registered at launch, passes the register of every cell in
// turn and is captured in the response register; one request is in flight
// at a time, so the walk along the cell chain paces the transactions.
// The response sits in an output register; the next request is taken as
// soon as the previous response reaches it. If the receiver stalls, a
// finished wave parks in a hold register and req_ready stays low until the
// output register frees up.
// Reset empties the table (count to zero); entry storage is not cleared
// and no cleanup pass runs, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_card_table
	import sct_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	cmd_t             cmd;
	logic [CMP_W-1:0] pos;
	logic [CMP_W-1:0] cnt;
	wave_t            wave [CAPACITY+1];
	logic [KEY_W-1:0] cell_key [CAPACITY];
	logic [PAY_W-1:0] cell_pay [CAPACITY];

	sct_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cmd      (cmd),
		.pos      (pos),
		.cnt      (cnt),
		.launch   (wave[0]),
		.tail     (wave[CAPACITY])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0] rkey;
		logic [PAY_W-1:0] rpay;

		if (i == CAPACITY - 1) begin : g_last
			assign rkey = '0;
			assign rpay = '0;
		end else begin : g_mid
			assign rkey = cell_key[i+1];
			assign rpay = cell_pay[i+1];
		end

		sct_cell #(
			.IDX  (i),
			.CMP_W(CMP_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.pos      (pos),
			.cnt      (cnt),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1]),
			.right_key(rkey),
			.right_pay(rpay),
			.own_key  (cell_key[i]),
			.own_pay  (cell_pay[i])
		);
	end

endmodule
`default_nettype wire

// ===== design/sct_checker.sv =====
// Port-level checks for the sorted card table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sct_checker
	import sct_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// failed operations report an empty entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.out_key == '0 && rsp.out_payload == '0)
		else $error("failed response carries entry data");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 255) || (int'(rsp.entry_count) <= CAPACITY))
		else $error("entry count above capacity");

endmodule

bind sorted_card_table sct_checker #(
	.CAPACITY(CAPACITY)
) u_sct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
`default_nettype wire
